/* rtl/core/sla_pkg.sv */
// ----------------------------------------------------------------------------
// sla_pkg
// shared types and constants of the serial line assembler
// ----------------------------------------------------------------------------
package sla_pkg;

   typedef logic [1:0] kind_type;

   localparam kind_type KIND_STORE    = 2'd0;
   localparam kind_type KIND_ECHO     = 2'd1;
   localparam kind_type KIND_COMPLETE = 2'd2;

   typedef logic [1:0] reg_index_type;

   localparam reg_index_type REG_BINARY_MODE     = 2'd0;
   localparam reg_index_type REG_ECHO_ENABLE     = 2'd1;
   localparam reg_index_type REG_MACHINE_REPLIES = 2'd2;

   localparam logic [7:0]  CHAR_BS    = 8'h08;
   localparam logic [7:0]  CHAR_LF    = 8'h0A;
   localparam logic [7:0]  CHAR_CR    = 8'h0D;
   localparam logic [7:0]  CHAR_SPACE = 8'h20;
   localparam logic [7:0]  CHAR_DEL   = 8'h7F;
   localparam logic [63:0] END_MARKER = 64'hBADC_0FFE_E00F_F00D;

   typedef struct packed {
      logic binary_mode;
      logic echo_enable;
      logic machine_replies;
   } cfg_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] position;
      logic [7:0] data_byte;
      logic [8:0] line_length;
   } result_type;

   typedef struct packed {
      logic [1:0]           count;
      result_type [2:0]     slot;
   } bundle_type;

endpackage

/* rtl/core/serial_line_assembler.sv */
// ----------------------------------------------------------------------------
// serial_line_assembler
// assembles received serial bytes into text or binary command lines
// ----------------------------------------------------------------------------
// Each received byte is captured in an input register and decoded into zero
// to three result beats (store, echo, line complete); a bundle with at least
// one beat enters a two-deep bundle queue once the queue has room. The result
// port moves one beat per cycle while rsp_ready is high, so a byte occupies the
// result port for as many beats as it has results, the first passing through
// the input register and a queue entry register. A new byte is taken every
// cycle while the queue has room. No clearing pass is needed after reset.
module serial_line_assembler
   import sla_pkg::*;
#(
   parameter int LINE_MAX = 256
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_position,
   output logic [7:0]  rsp_data_byte,
   output logic [8:0]  rsp_line_length,
   output logic        rsp_last,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic          in_valid_ff;
   logic [7:0]    in_byte_ff;
   cfg_type       cfg_ff;
   reg_index_type csr_index;
   logic          csr_write;
   logic          advance;
   logic          queue_full;
   bundle_type    bundle;
   result_type    rsp_result;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[3:2];
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      case (csr_index)
         REG_BINARY_MODE:     csr_prdata = {31'd0, cfg_ff.binary_mode};
         REG_ECHO_ENABLE:     csr_prdata = {31'd0, cfg_ff.echo_enable};
         REG_MACHINE_REPLIES: csr_prdata = {31'd0, cfg_ff.machine_replies};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.binary_mode     <= 1'b0;
         cfg_ff.echo_enable     <= 1'b1;
         cfg_ff.machine_replies <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_BINARY_MODE:     cfg_ff.binary_mode     <= csr_pwdata[0];
            REG_ECHO_ENABLE:     cfg_ff.echo_enable     <= csr_pwdata[0];
            REG_MACHINE_REPLIES: cfg_ff.machine_replies <= csr_pwdata[0];
            default:             cfg_ff                 <= cfg_ff;
         endcase
      end
   end

   assign advance   = in_valid_ff & ~queue_full;
   assign req_ready = ~in_valid_ff | advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   sla_line_engine #(
      .LINE_MAX (LINE_MAX)
   ) u_engine (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg_ff),
      .bundle  (bundle)
   );

   sla_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (advance && (bundle.count != 2'd0)),
      .bundle     (bundle),
      .full       (queue_full),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_result (rsp_result),
      .rsp_last   (rsp_last)
   );

   assign rsp_kind        = rsp_result.kind;
   assign rsp_position    = rsp_result.position;
   assign rsp_data_byte   = rsp_result.data_byte;
   assign rsp_line_length = rsp_result.line_length;

   // line complete always closes the results of its byte
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_COMPLETE) |-> rsp_last)
      else $error("line complete not last beat");

   // a byte's remaining beats follow without a gap
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> rsp_valid)
      else $error("result beats of one byte interrupted");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_COMPLETE) |->
         (rsp_position == 8'd0 && rsp_data_byte == 8'd0))
      else $error("line complete carries store fields");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_ECHO) |-> (rsp_line_length == 9'd0))
      else $error("echo carries a line length");

endmodule

/* rtl/core/sla_line_engine.sv */
// ----------------------------------------------------------------------------
// sla_line_engine
// line state and per-byte decode into a bundle of up to three results
// ----------------------------------------------------------------------------
module sla_line_engine
   import sla_pkg::*;
#(
   parameter int LINE_MAX = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   input  cfg_type    cfg,
   output bundle_type bundle
);

   localparam int PW = $clog2(LINE_MAX);
   localparam int CW = (PW + 1 > 9) ? PW + 1 : 9;

   logic [PW-1:0] pos_ff;
   logic [PW-1:0] pos_in;
   logic [63:0]   window_ff;
   logic [63:0]   window_in;

   logic [CW-1:0] pos_ext;
   logic [CW-1:0] next_pos;
   logic [PW-1:0] wrapped;
   logic [CW-1:0] bin_len;
   logic [63:0]   window_shift;
   logic [7:0]    store_byte;
   logic          char_echo;
   logic          is_erase;
   logic          is_cr;
   result_type    store_res;
   result_type    blank_res;

   always_comb begin
      pos_ext   = CW'(pos_ff);
      next_pos  = pos_ext + CW'(1);
      wrapped   = (next_pos >= CW'(LINE_MAX)) ? '0 : next_pos[PW-1:0];
      bin_len   = next_pos - CW'(8);
      char_echo = cfg.echo_enable & ~cfg.machine_replies;
      is_erase  = (rx_byte == CHAR_BS) || (rx_byte == CHAR_DEL);
      is_cr     = (rx_byte == CHAR_CR);

      store_byte   = (!cfg.binary_mode && is_cr) ? CHAR_SPACE : rx_byte;
      window_shift = {window_ff[55:0], store_byte};

      blank_res             = '0;
      store_res             = '0;
      store_res.kind        = KIND_STORE;
      store_res.position    = pos_ext[7:0];
      store_res.data_byte   = store_byte;

      bundle       = '0;
      bundle.slot  = {blank_res, blank_res, blank_res};
      pos_in       = pos_ff;
      window_in    = window_ff;

      if (cfg.binary_mode) begin
         bundle.slot[0] = store_res;
         window_in      = window_shift;
         if ((next_pos >= CW'(8)) && (window_shift == END_MARKER)) begin
            bundle.slot[1].kind        = KIND_COMPLETE;
            bundle.slot[1].line_length = bin_len[8:0];
            bundle.count               = 2'd2;
            pos_in                     = '0;
         end else begin
            bundle.count = 2'd1;
            pos_in       = wrapped;
         end
      end else if (is_erase) begin
         if (pos_ff != '0) begin
            pos_in = pos_ff - PW'(1);
            if (cfg.echo_enable) begin
               bundle.slot[0].kind      = KIND_ECHO;
               bundle.slot[0].data_byte = CHAR_BS;
               bundle.slot[1].kind      = KIND_ECHO;
               bundle.slot[1].data_byte = CHAR_SPACE;
               bundle.slot[2].kind      = KIND_ECHO;
               bundle.slot[2].data_byte = CHAR_BS;
               bundle.count             = 2'd3;
            end
         end
      end else if (is_cr) begin
         bundle.slot[0] = store_res;
         window_in      = window_shift;
         pos_in         = '0;
         if (char_echo) begin
            bundle.slot[1].kind        = KIND_ECHO;
            bundle.slot[1].data_byte   = CHAR_LF;
            bundle.slot[2].kind        = KIND_COMPLETE;
            bundle.slot[2].line_length = next_pos[8:0];
            bundle.count               = 2'd3;
         end else begin
            bundle.slot[1].kind        = KIND_COMPLETE;
            bundle.slot[1].line_length = next_pos[8:0];
            bundle.count               = 2'd2;
         end
      end else begin
         bundle.slot[0] = store_res;
         window_in      = window_shift;
         pos_in         = wrapped;
         if (char_echo) begin
            bundle.slot[1].kind      = KIND_ECHO;
            bundle.slot[1].data_byte = rx_byte;
            bundle.count             = 2'd2;
         end else begin
            bundle.count = 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         window_ff <= '0;
      end else if (step) begin
         pos_ff    <= pos_in;
         window_ff <= window_in;
      end
   end

endmodule

/* rtl/core/sla_result_queue.sv */
// ----------------------------------------------------------------------------
// sla_result_queue
// two-deep bundle queue, unrolled one beat per cycle while rsp_ready is high
// ----------------------------------------------------------------------------
module sla_result_queue
   import sla_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type bundle,
   output logic       full,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp_result,
   output logic       rsp_last
);

   bundle_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;
   logic [1:0] fill_in;
   logic [1:0] slot_ff;
   logic [1:0] slot_in;
   bundle_type head;
   logic       take;
   logic       pop;

   always_comb begin
      head       = entry_ff[rd_ptr_ff];
      full       = (fill_ff == 2'd2);
      rsp_valid  = (fill_ff != 2'd0);
      rsp_result = head.slot[slot_ff];
      rsp_last   = (slot_ff == head.count - 2'd1);
      take       = rsp_valid & rsp_ready;
      pop        = take & rsp_last;
      slot_in    = pop ? 2'd0 : (take ? slot_ff + 2'd1 : slot_ff);
      fill_in    = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
         slot_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_ff ^ push;
         rd_ptr_ff <= rd_ptr_ff ^ pop;
         fill_ff   <= fill_in;
         slot_ff   <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= bundle;
      end
   end

endmodule
